// ----- src/bfa_pkg.sv -----
package bfa_pkg;

  // Widths of the item fields.
  localparam int unsigned ADDR_W  = 27;
  localparam int unsigned BYTES_W = 28;

  // Each summary word holds one full flag per map word.
  localparam int unsigned SUM_BITS = 32;
  localparam int unsigned SUM_SH   = 5;

  // Operation codes carried by func.
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_OOM   = 2'd1,
    ST_DFREE = 2'd2
  } status_e;

endpackage

// ----- src/bfa_ram.sv -----
module bfa_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/bitmap_frame_allocator_top.sv -----
// Allocation: a group-flag search, one summary RAM read and one map RAM read/modify/write,
// plus a summary write if the word fills. Items are taken only in S_IDLE.
// Free: one map and one summary RAM read; both are written back if the frame was in use.
// Out of memory and a free beyond the map answer in the cycle after accept.
// After reset a clearing pass writes the map and summary RAMs, one word a cycle, over all
// ceil(NUM_FRAMES / WORD_BITS) map words (1024 by default); no item is accepted meanwhile.
module bitmap_frame_allocator_top
  import bfa_pkg::*;
#(
  parameter int unsigned NUM_FRAMES      = 32768,
  parameter int unsigned WORD_BITS       = 32,
  parameter int unsigned RESERVED_FRAMES = 1024,
  parameter int unsigned FRAME_BYTES     = 4096
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               func_i,
  input  logic [ADDR_W-1:0]  free_addr_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [ADDR_W-1:0]  frame_addr_o,
  output logic [1:0]         status_o,
  output logic [BYTES_W-1:0] free_bytes_o
);

  localparam int unsigned RES_CAP   = (RESERVED_FRAMES < NUM_FRAMES) ? RESERVED_FRAMES
                                                                     : NUM_FRAMES;
  localparam int unsigned WB_SH     = $clog2(WORD_BITS);
  localparam int unsigned FB_SH     = $clog2(FRAME_BYTES);
  localparam int unsigned MAP_WORDS = (NUM_FRAMES + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned GROUPS    = (MAP_WORDS + SUM_BITS - 1) / SUM_BITS;
  localparam int unsigned WIB       = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int unsigned GIB       = (GROUPS > 1) ? $clog2(GROUPS) : 1;
  localparam int unsigned WXB       = GIB + SUM_SH;
  localparam int unsigned FAW       = ADDR_W - FB_SH;
  localparam int unsigned UCW       = $clog2(NUM_FRAMES + 1);
  localparam int unsigned CLW       = $clog2(MAP_WORDS + 1);

  // A group is full when none of its frames lies in the initially free range.
  function automatic logic [GROUPS-1:0] grp_init();
    logic [GROUPS-1:0] v;
    longint s;
    for (int g = 0; g < GROUPS; g++) begin
      s = longint'(g) * SUM_BITS * WORD_BITS;
      v[g] = (s + SUM_BITS * WORD_BITS <= RES_CAP) || (s >= NUM_FRAMES) ||
             (RES_CAP == NUM_FRAMES);
    end
    return v;
  endfunction

  localparam logic [GROUPS-1:0] GRP_INIT = grp_init();

  // Reserved frames and frames past the end of the map read as used, so a search never lands there.
  function automatic logic [WORD_BITS-1:0] map_init(input logic [CLW-1:0] w);
    logic [WORD_BITS-1:0] v;
    longint f;
    for (int j = 0; j < WORD_BITS; j++) begin
      f = (longint'(w) << WB_SH) + j;
      v[j] = (f < RES_CAP) || (f >= NUM_FRAMES);
    end
    return v;
  endfunction

  function automatic logic [SUM_BITS-1:0] sum_init(input logic [CLW-1:0] g);
    logic [SUM_BITS-1:0] v;
    longint s;
    for (int k = 0; k < SUM_BITS; k++) begin
      s = ((longint'(g) << SUM_SH) + k) << WB_SH;
      v[k] = (s + WORD_BITS <= RES_CAP) || (s >= NUM_FRAMES) || (RES_CAP == NUM_FRAMES);
    end
    return v;
  endfunction

  typedef enum logic [2:0] {
    S_CLR,
    S_IDLE,
    S_SUM,
    S_MAP,
    S_FMAP
  } state_e;

  state_e              state_q;
  logic [CLW-1:0]      clr_q;
  logic [GROUPS-1:0]   grp_full_q;
  logic [UCW-1:0]      used_q;
  logic [GIB-1:0]      g_q;
  logic [SUM_SH-1:0]   k_q;
  logic [WB_SH-1:0]    b_q;
  logic                out_valid_q;
  logic [ADDR_W-1:0]   frame_addr_q;
  status_e             status_q;
  logic [BYTES_W-1:0]  free_bytes_q;

  logic                in_acc;
  logic [GIB-1:0]      g_sel;
  logic [SUM_SH-1:0]   k_sel;
  logic [WB_SH-1:0]    b_sel;
  logic [FAW-1:0]      free_frame;
  logic                free_in_map;
  logic [WXB-1:0]      free_word;
  logic [WXB-1:0]      cur_word;
  logic [WXB-1:0]      sum_word;

  logic                map_we;
  logic [WIB-1:0]      map_waddr;
  logic [WORD_BITS-1:0] map_wdata;
  logic [WIB-1:0]      map_raddr;
  logic [WORD_BITS-1:0] map_rdata;
  logic                sum_we;
  logic [GIB-1:0]      sum_waddr;
  logic [SUM_BITS-1:0] sum_wdata;
  logic [GIB-1:0]      sum_raddr;
  logic [SUM_BITS-1:0] sum_rdata;

  logic [WORD_BITS-1:0] map_set;
  logic [WORD_BITS-1:0] map_clr;
  logic [SUM_BITS-1:0]  sum_set;
  logic [SUM_BITS-1:0]  sum_clr;
  logic                 bit_used;
  logic [UCW-1:0]       used_inc;
  logic [UCW-1:0]       used_dec;

  assign in_ready_o = (state_q == S_IDLE) && (!out_valid_q || out_ready_i);
  assign in_acc     = in_valid_i && in_ready_o;

  assign free_frame  = free_addr_i[ADDR_W-1:FB_SH];
  assign free_in_map = 32'(free_frame) < 32'(NUM_FRAMES);
  assign free_word   = WXB'(free_frame >> WB_SH);
  assign sum_word    = {g_q, k_sel};
  assign cur_word    = {g_q, k_q};

  // Lowest group that still has a word with a free frame.
  always_comb begin
    g_sel = '0;
    for (int i = GROUPS - 1; i >= 0; i--) begin
      if (!grp_full_q[i]) begin
        g_sel = GIB'(i);
      end
    end
  end

  // Lowest word of the group that is not full.
  always_comb begin
    k_sel = '0;
    for (int i = SUM_BITS - 1; i >= 0; i--) begin
      if (!sum_rdata[i]) begin
        k_sel = SUM_SH'(i);
      end
    end
  end

  // Lowest free frame within the word.
  always_comb begin
    b_sel = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (!map_rdata[i]) begin
        b_sel = WB_SH'(i);
      end
    end
  end

  assign map_set  = map_rdata | (WORD_BITS'(1) << b_sel);
  assign map_clr  = map_rdata & ~(WORD_BITS'(1) << b_q);
  assign sum_set  = sum_rdata | (SUM_BITS'(1) << k_q);
  assign sum_clr  = sum_rdata & ~(SUM_BITS'(1) << k_q);
  assign bit_used = map_rdata[b_q];
  assign used_inc = used_q + UCW'(1);
  assign used_dec = used_q - UCW'(1);

  // RAM read addresses hold steady after the read so the data stays valid.
  always_comb begin
    unique case (state_q)
      S_IDLE:  begin
        sum_raddr = (func_i == OP_FREE) ? free_word[WXB-1:SUM_SH] : g_sel;
        map_raddr = free_word[WIB-1:0];
      end
      S_SUM:   begin
        sum_raddr = g_q;
        map_raddr = sum_word[WIB-1:0];
      end
      default: begin
        sum_raddr = g_q;
        map_raddr = cur_word[WIB-1:0];
      end
    endcase
  end

  always_comb begin
    map_we    = 1'b0;
    map_waddr = cur_word[WIB-1:0];
    map_wdata = map_set;
    sum_we    = 1'b0;
    sum_waddr = g_q;
    sum_wdata = sum_set;
    unique case (state_q)
      S_CLR:   begin
        map_we    = 1'b1;
        map_waddr = clr_q[WIB-1:0];
        map_wdata = map_init(clr_q);
        sum_we    = 32'(clr_q) < 32'(GROUPS);
        sum_waddr = clr_q[GIB-1:0];
        sum_wdata = sum_init(clr_q);
      end
      S_MAP:   begin
        map_we = 1'b1;
        sum_we = &map_set;
      end
      S_FMAP:  begin
        map_wdata = map_clr;
        map_we    = bit_used;
        sum_wdata = sum_clr;
        sum_we    = bit_used;
      end
      default: begin
      end
    endcase
  end

  bfa_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (MAP_WORDS)
  ) u_map_ram (
    .clk_i   (clk_i),
    .we_i    (map_we),
    .waddr_i (map_waddr),
    .wdata_i (map_wdata),
    .raddr_i (map_raddr),
    .rdata_o (map_rdata)
  );

  bfa_ram #(
    .WIDTH (SUM_BITS),
    .DEPTH (GROUPS)
  ) u_sum_ram (
    .clk_i   (clk_i),
    .we_i    (sum_we),
    .waddr_i (sum_waddr),
    .wdata_i (sum_wdata),
    .raddr_i (sum_raddr),
    .rdata_o (sum_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLR;
      clr_q        <= '0;
      grp_full_q   <= GRP_INIT;
      used_q       <= UCW'(RES_CAP);
      g_q          <= '0;
      k_q          <= '0;
      b_q          <= '0;
      out_valid_q  <= 1'b0;
      frame_addr_q <= '0;
      status_q     <= ST_OK;
      free_bytes_q <= '0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_CLR: begin
          clr_q <= clr_q + CLW'(1);
          if (32'(clr_q) == MAP_WORDS - 1) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_acc) begin
            if (func_i == OP_ALLOC) begin
              g_q <= g_sel;
              if (&grp_full_q) begin
                out_valid_q  <= 1'b1;
                frame_addr_q <= '0;
                status_q     <= ST_OOM;
                free_bytes_q <= BYTES_W'({UCW'(NUM_FRAMES) - used_q, {FB_SH{1'b0}}});
              end else begin
                state_q <= S_SUM;
              end
            end else begin
              g_q <= free_word[WXB-1:SUM_SH];
              k_q <= free_word[SUM_SH-1:0];
              b_q <= free_frame[WB_SH-1:0];
              if (free_in_map) begin
                state_q <= S_FMAP;
              end else begin
                // A frame beyond the map is ignored and reported as done.
                out_valid_q  <= 1'b1;
                frame_addr_q <= '0;
                status_q     <= ST_OK;
                free_bytes_q <= BYTES_W'({UCW'(NUM_FRAMES) - used_q, {FB_SH{1'b0}}});
              end
            end
          end
        end
        S_SUM: begin
          k_q     <= k_sel;
          state_q <= S_MAP;
        end
        S_MAP: begin
          if (&map_set) begin
            grp_full_q[g_q] <= &sum_set;
          end
          used_q       <= used_inc;
          out_valid_q  <= 1'b1;
          frame_addr_q <= ADDR_W'({g_q, k_q, b_sel, {FB_SH{1'b0}}});
          status_q     <= ST_OK;
          free_bytes_q <= BYTES_W'({UCW'(NUM_FRAMES) - used_inc, {FB_SH{1'b0}}});
          state_q      <= S_IDLE;
        end
        S_FMAP: begin
          out_valid_q  <= 1'b1;
          frame_addr_q <= '0;
          if (bit_used) begin
            grp_full_q[g_q] <= 1'b0;
            used_q          <= used_dec;
            status_q        <= ST_OK;
            free_bytes_q    <= BYTES_W'({UCW'(NUM_FRAMES) - used_dec, {FB_SH{1'b0}}});
          end else begin
            status_q     <= ST_DFREE;
            free_bytes_q <= BYTES_W'({UCW'(NUM_FRAMES) - used_q, {FB_SH{1'b0}}});
          end
          state_q <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o  = out_valid_q;
  assign frame_addr_o = frame_addr_q;
  assign status_o     = status_q;
  assign free_bytes_o = free_bytes_q;

endmodule
